### rtl/mav_pkg.sv
// mav_pkg: shared constants for the mesh area/volume accumulator
// no dependencies; compiled first
package mav_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int AREA_BITS      = 35;
  localparam int VOL_BITS       = 47;
  localparam int TAREA_BITS     = 51;
  localparam int TVOL_BITS      = 61;
  localparam int SUM6_BITS      = 64;
  localparam int RAD_BITS       = 70;
  localparam int NUM_STEPS      = 21;

endpackage

### rtl/mav_if.sv
// mav_in_if / mav_out_if: valid/ready channels for triangles and results
// depends on mav_pkg
interface mav_in_if;
  logic valid;
  logic ready;
  logic [mav_pkg::FIELD_BITS-1:0] v1_x, v1_y, v1_z;
  logic [mav_pkg::FIELD_BITS-1:0] v2_x, v2_y, v2_z;
  logic [mav_pkg::FIELD_BITS-1:0] v3_x, v3_y, v3_z;
  logic last_triangle;
  modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  v3_x, v3_y, v3_z, last_triangle, input ready);
  modport sink (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                v3_x, v3_y, v3_z, last_triangle, output ready);
endinterface

interface mav_out_if;
  logic valid;
  logic ready;
  logic [mav_pkg::AREA_BITS-1:0]  tri_area;
  logic [mav_pkg::VOL_BITS-1:0]   tri_volume;
  logic [mav_pkg::TAREA_BITS-1:0] total_area;
  logic [mav_pkg::TVOL_BITS-1:0]  mesh_volume;
  logic mesh_done;
  modport source (output valid, tri_area, tri_volume, total_area, mesh_volume,
                  mesh_done, input ready);
  modport sink (input valid, tri_area, tri_volume, total_area, mesh_volume,
                mesh_done, output ready);
endinterface

### rtl/mav_sqrt.sv
// mav_sqrt: digit-by-digit floor integer square root, one root bit per cycle
// depends on mav_pkg
module mav_sqrt #(
  parameter int RBITS = mav_pkg::RAD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RBITS-1:0]     radicand,
  output logic                 busy,
  output logic [RBITS/2-1:0]   root
);
  import mav_pkg::*;
  localparam int QB = RBITS / 2;
  localparam int CB = $clog2(QB + 1);
  localparam int WB = QB + 4;

  logic [RBITS-1:0] rad_r, rad_nxt;
  logic [QB-1:0]    q_r, q_nxt;
  logic [WB-1:0]    rem_r, rem_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [WB-1:0]    shifted, trial;

  always_comb begin
    shifted  = {rem_r[WB-3:0], rad_r[RBITS-1 -: 2]};
    trial    = WB'({q_r, 2'b01});
    rad_nxt  = rad_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = CB'(QB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r <= rad_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign root = q_r;

  a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("sqrt busy with zero count");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("sqrt did not start");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CB'(1) && !start) |=> !busy_r) else $error("sqrt overran");
endmodule

### rtl/mav_div6.sv
// mav_div6: unsigned division by six; halve, then divide by three with a
// shift-add series and a small remainder fix; depends on mav_pkg
module mav_div6 #(
  parameter int DBITS = mav_pkg::SUM6_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DBITS-1:0] dividend,
  output logic             busy,
  output logic [DBITS-1:0] quotient
);
  import mav_pkg::*;
  localparam int STEPS = 6;
  localparam int CB    = $clog2(STEPS + 1);

  logic [DBITS-1:0] num_r, num_nxt;
  logic [DBITS-1:0] q_r, q_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [4:0]       rem;
  logic [8:0]       fix;

  always_comb begin
    // series result undershoots by less than 32, so five remainder bits do
    rem = num_r[4:0] - q_r[4:0] - {q_r[3:0], 1'b0};
    // rem * 11 / 32 is rem / 3 for rem below 32
    fix = {4'd0, rem} + {3'd0, rem, 1'b0} + {1'b0, rem, 3'd0};
    num_nxt  = num_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = dividend >> 1;
      q_nxt    = '0;
      cnt_nxt  = CB'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (cnt_r)
        CB'(6):  q_nxt = (num_r >> 2) + (num_r >> 4);
        CB'(5):  q_nxt = q_r + (q_r >> 4);
        CB'(4):  q_nxt = q_r + (q_r >> 8);
        CB'(3):  q_nxt = q_r + (q_r >> 16);
        CB'(2):  q_nxt = q_r + (q_r >> 32);
        CB'(1):  q_nxt = q_r + DBITS'(fix[8:5]);
        default: q_nxt = q_r;
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && cnt_r == CB'(STEPS))) else $error("div6 did not start");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("div6 busy with zero count");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CB'(1) && !start) |=> !busy_r) else $error("div6 overran");
endmodule

### rtl/mesh_area_volume_accumulator.sv
// mesh_area_volume_accumulator: top level, sequencer around a shared multiplier
// depends on mav_pkg, mav_if, mav_sqrt, mav_div6
//
// usage
// - in_if carries one triangle per beat (nine signed coordinates, 8 fraction
//   bits, low COORD_BITS bits used) plus last_triangle
// - out_if carries one result beat per triangle: area, signed volume, and on
//   the last triangle the mesh totals with mesh_done set
// - per triangle: the shared 36x18 multiplier steps through the cross product,
//   determinant and squared length (S_MUL), then a launch state, a wait on the
//   square root unit (the volume division by six runs alongside), an accumulate
//   state and an output load state, from accept to result
// - the last triangle adds the total-volume division (S_TLAUNCH, S_TOTAL)
// - in_ready is high only in idle; a pending result in the output register
//   does not block a new accept, only the final load of the next result
// - if out_ready stays low the sequencer holds its result until the output
//   register frees up
// - synchronous reset clears sums, sequencer and output valid
module mesh_area_volume_accumulator #(
  parameter int COORD_BITS = mav_pkg::COORD_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  mav_in_if.sink  in_if,
  mav_out_if.source out_if
);
  import mav_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_LAUNCH, S_ROOT, S_ACCUM, S_TLAUNCH, S_TOTAL, S_DONE
  } state_t;

  localparam int SB  = $clog2(NUM_STEPS);
  localparam int SHF = FIELD_BITS - COORD_BITS;
  localparam logic [TAREA_BITS-1:0] AREA_MAX = '1;

  function automatic logic signed [17:0] crd(input logic [FIELD_BITS-1:0] raw);
    logic [FIELD_BITS-1:0] sh;
    sh  = raw << SHF;
    crd = 18'(signed'(sh) >>> SHF);
  endfunction

  function automatic logic signed [35:0] mag36(input logic signed [35:0] v);
    mag36 = v[35] ? -v : v;
  endfunction

  state_t state_r;
  logic [SB-1:0] step_r;
  logic last_r;
  logic signed [17:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r, x3_r, y3_r, z3_r;
  logic signed [17:0] a1_r, a2_r, a3_r, b1_r, b2_r, b3_r;
  logic signed [35:0] t_r, m_r, c0_r, c1_r, c2_r;
  logic signed [51:0] det_r;
  logic [RAD_BITS-1:0] sq_r;
  logic [TAREA_BITS-1:0] area_sum_r;
  logic signed [SUM6_BITS-1:0] vol6_sum_r;
  logic [AREA_BITS-1:0] area_r;
  logic [VOL_BITS-1:0] vol_r;

  logic out_valid_r;
  logic [AREA_BITS-1:0] o_area_r;
  logic [VOL_BITS-1:0] o_vol_r;
  logic [TAREA_BITS-1:0] o_tarea_r;
  logic [TVOL_BITS-1:0] o_tvol_r;
  logic o_done_r;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] prod;
  logic signed [35:0] mc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mc    = '0;
    case (step_r)
      5'd0:  begin mul_a = 36'(a2_r); mul_b = b3_r; end
      5'd1:  begin mul_a = 36'(a3_r); mul_b = b2_r; end
      5'd2:  begin mul_a = 36'(a3_r); mul_b = b1_r; end
      5'd3:  begin mul_a = 36'(a1_r); mul_b = b3_r; end
      5'd4:  begin mul_a = 36'(a1_r); mul_b = b2_r; end
      5'd5:  begin mul_a = 36'(a2_r); mul_b = b1_r; end
      5'd6:  begin mul_a = 36'(y2_r); mul_b = z3_r; end
      5'd7:  begin mul_a = 36'(z2_r); mul_b = y3_r; end
      5'd8:  begin mul_a = m_r;       mul_b = x1_r; end
      5'd9:  begin mul_a = 36'(z2_r); mul_b = x3_r; end
      5'd10: begin mul_a = 36'(x2_r); mul_b = z3_r; end
      5'd11: begin mul_a = m_r;       mul_b = y1_r; end
      5'd12: begin mul_a = 36'(x2_r); mul_b = y3_r; end
      5'd13: begin mul_a = 36'(y2_r); mul_b = x3_r; end
      5'd14: begin mul_a = m_r;       mul_b = z1_r; end
      5'd15: begin mc = mag36(c0_r); mul_a = mc; mul_b = {1'b0, mc[16:0]}; end
      5'd16: begin mc = mag36(c0_r); mul_a = mc; mul_b = {1'b0, mc[33:17]}; end
      5'd17: begin mc = mag36(c1_r); mul_a = mc; mul_b = {1'b0, mc[16:0]}; end
      5'd18: begin mc = mag36(c1_r); mul_a = mc; mul_b = {1'b0, mc[33:17]}; end
      5'd19: begin mc = mag36(c2_r); mul_a = mc; mul_b = {1'b0, mc[16:0]}; end
      5'd20: begin mc = mag36(c2_r); mul_a = mc; mul_b = {1'b0, mc[33:17]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  // iterative units
  logic sq_start, sq_busy, dv_start, dv_busy;
  logic [AREA_BITS-1:0] root;
  logic [SUM6_BITS-1:0] dv_in, dv_q;
  logic [SUM6_BITS-1:0] det_mag, sum_mag;

  assign det_mag = 64'(unsigned'(det_r[51] ? -det_r : det_r));
  assign sum_mag = vol6_sum_r[SUM6_BITS-1] ? (64'd0 - 64'(vol6_sum_r)) : 64'(vol6_sum_r);
  assign sq_start = (state_r == S_LAUNCH);
  assign dv_start = (state_r == S_LAUNCH) || (state_r == S_TLAUNCH);
  assign dv_in = (state_r == S_TLAUNCH) ? sum_mag : det_mag;

  mav_sqrt #(.RBITS(RAD_BITS)) u_sqrt (
    .clk, .rst_n, .start(sq_start), .radicand(sq_r),
    .busy(sq_busy), .root(root)
  );

  mav_div6 #(.DBITS(SUM6_BITS)) u_div6 (
    .clk, .rst_n, .start(dv_start), .dividend(dv_in),
    .busy(dv_busy), .quotient(dv_q)
  );

  // sum updates
  logic [TAREA_BITS:0] area_add;
  logic signed [SUM6_BITS-1:0] det64, vol_add;
  logic vol_ovf;
  assign area_add = {1'b0, area_sum_r} + (TAREA_BITS+1)'(area_r);
  assign det64    = 64'(det_r);
  assign vol_add  = vol6_sum_r + det64;
  assign vol_ovf  = (vol6_sum_r[63] == det64[63]) && (vol_add[63] != det64[63]);

  logic in_acc, out_free, out_load;
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = (state_r == S_DONE) && out_free;
  assign in_if.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      area_sum_r  <= '0;
      vol6_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new load wins over the drain of the old beat
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x1_r <= crd(in_if.v1_x); y1_r <= crd(in_if.v1_y); z1_r <= crd(in_if.v1_z);
            x2_r <= crd(in_if.v2_x); y2_r <= crd(in_if.v2_y); z2_r <= crd(in_if.v2_z);
            x3_r <= crd(in_if.v3_x); y3_r <= crd(in_if.v3_y); z3_r <= crd(in_if.v3_z);
            a1_r <= crd(in_if.v2_x) - crd(in_if.v1_x);
            a2_r <= crd(in_if.v2_y) - crd(in_if.v1_y);
            a3_r <= crd(in_if.v2_z) - crd(in_if.v1_z);
            b1_r <= crd(in_if.v3_x) - crd(in_if.v1_x);
            b2_r <= crd(in_if.v3_y) - crd(in_if.v1_y);
            b3_r <= crd(in_if.v3_z) - crd(in_if.v1_z);
            last_r  <= in_if.last_triangle;
            det_r   <= '0;
            sq_r    <= '0;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          case (step_r)
            5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12: t_r <= prod[35:0];
            5'd1:  c0_r <= t_r - prod[35:0];
            5'd3:  c1_r <= t_r - prod[35:0];
            5'd5:  c2_r <= t_r - prod[35:0];
            5'd7, 5'd10, 5'd13: m_r <= t_r - prod[35:0];
            5'd8, 5'd11, 5'd14: det_r <= det_r + prod[51:0];
            5'd15, 5'd17, 5'd19: sq_r <= sq_r + RAD_BITS'(prod[51:0]);
            5'd16, 5'd18, 5'd20: sq_r <= sq_r + (RAD_BITS'(prod[51:0]) << 17);
            default: t_r <= t_r;
          endcase
          if (step_r == SB'(NUM_STEPS - 1)) state_r <= S_LAUNCH;
          else step_r <= step_r + 1'b1;
        end
        S_LAUNCH: state_r <= S_ROOT;
        S_ROOT: begin
          if (!sq_busy && !dv_busy) begin
            area_r  <= root;
            vol_r   <= VOL_BITS'(det_r[51] ? (64'd0 - dv_q) : dv_q);
            state_r <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          area_sum_r <= area_add[TAREA_BITS] ? AREA_MAX : area_add[TAREA_BITS-1:0];
          if (vol_ovf)
            vol6_sum_r <= det64[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          else
            vol6_sum_r <= vol_add;
          state_r <= last_r ? S_TLAUNCH : S_DONE;
        end
        S_TLAUNCH: state_r <= S_TOTAL;
        S_TOTAL:   if (!dv_busy) state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            o_area_r    <= area_r;
            o_vol_r     <= vol_r;
            o_done_r    <= last_r;
            o_tarea_r   <= last_r ? area_sum_r : '0;
            o_tvol_r    <= last_r ? dv_q[TVOL_BITS-1:0] : '0;
            if (last_r) begin
              area_sum_r <= '0;
              vol6_sum_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.tri_area     = o_area_r;
  assign out_if.tri_volume   = o_vol_r;
  assign out_if.total_area   = o_tarea_r;
  assign out_if.mesh_volume  = o_tvol_r;
  assign out_if.mesh_done    = o_done_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready) else $error("accepted while working");
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!sq_busy && !dv_busy)) else $error("unit busy in idle");
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (area_sum_r == '0 && vol6_sum_r == '0))
    else $error("sums not cleared after last triangle");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r) else $error("result not loaded");
endmodule
